[hw/rtl/prri_pkg.sv]
// shared types and codes of the palette converter register interface
`default_nettype none

package prri_pkg;

  // one palette entry: red in 23..16, green in 15..8, blue in 7..0
  typedef logic [23:0] rgb_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_WADDR  = 3'd0,
    REG_PDATA  = 3'd1,
    REG_MASK   = 3'd2,
    REG_RADDR  = 3'd3,
    REG_OWADDR = 3'd4,
    REG_ODATA  = 3'd5,
    REG_RSVD   = 3'd6,
    REG_ORADDR = 3'd7
  } reg_sel_t;

  typedef enum logic [1:0] {
    PH_RED   = 2'd0,
    PH_GREEN = 2'd1,
    PH_BLUE  = 2'd2,
    PH_STRAY = 2'd3
  } phase_t;

endpackage

`default_nettype wire

[hw/rtl/prri_palette_mem.sv]
// one palette store: synchronous memory, one write port, registered read port
`default_nettype none

module prri_palette_mem
  import prri_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire rgb_t                     wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output rgb_t                          rd_data
);

  rgb_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/palette_ramdac_register_interface.sv]
// top level: register side and pixel lookup of a palette converter with overlay
//
// input stream (s_*): one transaction per bus access or pixel lookup;
//   tuser carries the operation and the register select, tdata the write
//   byte, the pixel index and the overlay index
// output stream (m_*): exactly one transaction per input transaction, in order;
//   tdata carries the read byte and the looked-up red, green and blue,
//   each zero where the operation does not produce it
// m_tvalid rises once the accepted item's palette read has returned,
//   later only while the output register still holds an unread result
// no new item is taken before the last is through; the main and overlay palettes are
//   synchronous memories with a registered read port, and an item holds the
//   block until its palette read has returned
// color writes are stored on the blue byte; the next item is only accepted
//   after that write has landed, so reads never see stale entries
// reset clears the address, phase, holding and mask registers and empties the
//   output register; palette contents stay undefined until written
// a stalled receiver keeps the result in the output register; one more item
//   can be accepted and is held, finished, until the output register frees up
`default_nettype none

module palette_ramdac_register_interface
  import prri_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int OVERLAY_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // write_data, pixel_index, overlay_index, zero pad
  input  wire logic [4:0]  s_tuser,   // operation, reg_select
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // read_data, red, green, blue
);

  localparam int MAIN_AW = $clog2(PALETTE_DEPTH);
  localparam int OVL_AW  = $clog2(OVERLAY_DEPTH);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;
  typedef enum logic [1:0] {K_NONE, K_PIXEL, K_FETCH} kind_t;

  state_t      state;
  // architectural registers
  logic [7:0]  color_address;
  phase_t      component_phase;
  logic [15:0] red_green_hold;
  rgb_t        read_hold;
  logic [7:0]  pixel_mask;
  // item waiting for its palette read
  kind_t       pend_kind;
  logic        pend_ovl;
  logic        pend_hit;
  logic [7:0]  pend_rd;

  // input transaction fields
  op_t         op;
  reg_sel_t    sel;
  logic [7:0]  wdata;
  logic [7:0]  pix;
  logic [3:0]  ovl;
  logic        accept;

  // next values decided at accept
  logic [7:0]  color_address_next;
  phase_t      component_phase_next;
  logic [15:0] red_green_hold_next;
  logic [7:0]  pixel_mask_next;
  logic [7:0]  rd_val;
  kind_t       kind;
  logic        fetch_ovl;
  logic [7:0]  fetch_idx;
  logic        fetch_hit;
  logic        store;
  logic        store_ovl;
  logic        store_hit;

  rgb_t        main_q;
  rgb_t        ovl_q;
  rgb_t        entry;
  logic        done;

  assign op     = op_t'(s_tuser[1:0]);
  assign sel    = reg_sel_t'(s_tuser[4:2]);
  assign wdata  = s_tdata[7:0];
  assign pix    = s_tdata[15:8];
  assign ovl    = s_tdata[19:16];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    color_address_next   = color_address;
    component_phase_next = component_phase;
    red_green_hold_next  = red_green_hold;
    pixel_mask_next      = pixel_mask;
    rd_val               = '0;
    kind                 = K_NONE;
    fetch_ovl            = 1'b0;
    fetch_idx            = color_address;
    store                = 1'b0;
    store_ovl            = (sel == REG_ODATA);

    case (op)
      OP_WRITE: begin
        case (sel)
          REG_WADDR, REG_OWADDR: begin
            color_address_next   = wdata;
            component_phase_next = PH_RED;
          end
          REG_RADDR, REG_ORADDR: begin
            // prefetch entry wdata into read_hold; address becomes wdata + 1
            color_address_next   = wdata + 8'd1;
            component_phase_next = PH_RED;
            kind                 = K_FETCH;
            fetch_ovl            = (sel == REG_ORADDR);
            fetch_idx            = wdata;
          end
          REG_MASK: pixel_mask_next = wdata;
          REG_PDATA, REG_ODATA: begin
            case (component_phase)
              PH_RED: begin
                red_green_hold_next  = {wdata, red_green_hold[7:0]};
                component_phase_next = PH_GREEN;
              end
              PH_GREEN: begin
                red_green_hold_next  = {red_green_hold[15:8], wdata};
                component_phase_next = PH_BLUE;
              end
              default: begin
                // blue, or a stray phase acting as blue
                store                = 1'b1;
                color_address_next   = color_address + 8'd1;
                component_phase_next = PH_RED;
              end
            endcase
          end
          default: ;
        endcase
      end
      OP_READ: begin
        case (sel)
          REG_WADDR, REG_RADDR, REG_OWADDR, REG_ORADDR: rd_val = color_address;
          REG_MASK: rd_val = pixel_mask;
          REG_PDATA, REG_ODATA: begin
            case (component_phase)
              PH_RED: begin
                rd_val               = read_hold[23:16];
                component_phase_next = PH_GREEN;
              end
              PH_GREEN: begin
                rd_val               = read_hold[15:8];
                component_phase_next = PH_BLUE;
              end
              default: begin
                rd_val               = read_hold[7:0];
                component_phase_next = PH_RED;
                color_address_next   = color_address + 8'd1;
                kind                 = K_FETCH;
                fetch_ovl            = (sel == REG_ODATA);
              end
            endcase
          end
          default: ;
        endcase
      end
      OP_LOOKUP: begin
        kind = K_PIXEL;
        if (ovl != 4'd0) begin
          fetch_ovl = 1'b1;
          fetch_idx = {4'd0, ovl};
        end else begin
          fetch_idx = pix & pixel_mask;
        end
      end
      default: ;
    endcase
  end

  // entries at or beyond a palette's depth are absent
  assign fetch_hit = fetch_ovl ? ({1'b0, fetch_idx} < 9'(OVERLAY_DEPTH))
                               : ({1'b0, fetch_idx} < 9'(PALETTE_DEPTH));
  assign store_hit = store_ovl ? ({1'b0, color_address} < 9'(OVERLAY_DEPTH))
                               : ({1'b0, color_address} < 9'(PALETTE_DEPTH));

  prri_palette_mem #(
    .DEPTH (PALETTE_DEPTH)
  ) u_main_mem (
    .clk     (clk),
    .wr_en   (accept && store && !store_ovl && store_hit),
    .wr_addr (color_address[MAIN_AW-1:0]),
    .wr_data ({red_green_hold, wdata}),
    .rd_en   (accept && (kind != K_NONE) && !fetch_ovl && fetch_hit),
    .rd_addr (fetch_idx[MAIN_AW-1:0]),
    .rd_data (main_q)
  );

  prri_palette_mem #(
    .DEPTH (OVERLAY_DEPTH)
  ) u_ovl_mem (
    .clk     (clk),
    .wr_en   (accept && store && store_ovl && store_hit),
    .wr_addr (color_address[OVL_AW-1:0]),
    .wr_data ({red_green_hold, wdata}),
    .rd_en   (accept && (kind != K_NONE) && fetch_ovl && fetch_hit),
    .rd_addr (fetch_idx[OVL_AW-1:0]),
    .rd_data (ovl_q)
  );

  // returned entry, zero for an absent one
  assign entry = pend_hit ? (pend_ovl ? ovl_q : main_q) : '0;
  assign done  = (state == ST_EXEC) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      m_tvalid        <= 1'b0;
      color_address   <= '0;
      component_phase <= PH_RED;
      red_green_hold  <= '0;
      read_hold       <= '0;
      pixel_mask      <= '0;
      pend_kind       <= K_NONE;
    end else begin
      // a new result replaces one taken in the same cycle
      if (done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            color_address   <= color_address_next;
            component_phase <= component_phase_next;
            red_green_hold  <= red_green_hold_next;
            pixel_mask      <= pixel_mask_next;
            pend_kind       <= kind;
            pend_ovl        <= fetch_ovl;
            pend_hit        <= fetch_hit;
            pend_rd         <= rd_val;
            state           <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (done) begin
            if (pend_kind == K_FETCH) begin
              read_hold <= entry;
            end
            if (pend_kind == K_PIXEL) begin
              m_tdata <= {entry[7:0], entry[15:8], entry[23:16], pend_rd};
            end else begin
              m_tdata <= {24'd0, pend_rd};
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
